FILE: design/assert_macros.svh
// assertion macros shared by the hue keyed desaturation design
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HKD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HKD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`else

`define HKD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define HKD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`endif

`endif

FILE: design/hkd_pkg.sv
// types and constants of the hue keyed desaturation pipeline
// no dependencies; used by every module of the block
package hkd_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned HUE_W      = 9;
    localparam int unsigned DEN_W      = 8;
    localparam int unsigned QUO_W      = 6;
    localparam int unsigned REM_W      = 14;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned RECIP_W    = 17;
    localparam int unsigned PROD_W     = SUM_W + RECIP_W;
    localparam int unsigned LUMA_SHIFT = 26;
    localparam int unsigned CELL_COUNT = QUO_W;
    localparam int unsigned LATENCY    = CELL_COUNT + 3;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_HUE_LOW  = 2'd0;
    localparam t_cfg_index CFG_HUE_HIGH = 2'd1;

    localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 9'd180;
    localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 9'd230;
    localparam logic [HUE_W-1:0] HUE_MAX        = 9'd359;

    localparam logic [HUE_W-1:0] HUE_BASE_RED     = 9'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN   = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE    = 9'd240;
    localparam logic [HUE_W-1:0] HUE_BASE_WRAP    = 9'd360;

    localparam logic [SUM_W-1:0]   LUMA_WR    = 18'd299;
    localparam logic [SUM_W-1:0]   LUMA_WG    = 18'd587;
    localparam logic [SUM_W-1:0]   LUMA_WB    = 18'd114;
    // floor(s / 1000) == (s * 67109) >> 26 for every s up to 255000
    localparam logic [RECIP_W-1:0] LUMA_RECIP = 17'd67109;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [HUE_W-1:0]  base;
        logic              sub;
        logic [SUM_W-1:0]  sum;
    } t_pix;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        t_pix             pix;
    } t_div;

endpackage

FILE: design/hue_keyed_desaturation_top.sv
// top level of the hue keyed desaturation block
// depends on hkd_pkg, hkd_front, hkd_cell and assert_macros.svh
//
// usage
//   a pixel request is taken at a clock edge with start high and busy low.
//   busy is high only while reset is held and until r_run is set after it, so a pixel may be
//   offered in every cycle after that.
//   each result appears on o_red_out, o_green_out, o_blue_out and o_hue_deg
//   for exactly one cycle with o_done high, after passing in order through
//   one front stage, six divider cells (one quotient bit each), a hue and
//   luma stage, and the range compare into the output register.
//   throughput is one pixel per clock; results leave in request order.
//   the receiver cannot stall, so nothing is held back.
//   the hue range registers are written on the cfg channel (index 0 low,
//   index 1 high, other indices ignored); o_cfg_ready is always high.
//   reset clears every valid bit and loads the range 180 to 230.
module hue_keyed_desaturation_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hkd_pkg::CHAN_W-1:0]  i_red_in,
    input  logic [hkd_pkg::CHAN_W-1:0]  i_green_in,
    input  logic [hkd_pkg::CHAN_W-1:0]  i_blue_in,
    output logic                        o_done,
    output logic [hkd_pkg::CHAN_W-1:0]  o_red_out,
    output logic [hkd_pkg::CHAN_W-1:0]  o_green_out,
    output logic [hkd_pkg::CHAN_W-1:0]  o_blue_out,
    output logic [hkd_pkg::HUE_W-1:0]   o_hue_deg,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  hkd_pkg::t_cfg_index         i_cfg_index,
    input  logic [hkd_pkg::HUE_W-1:0]   i_cfg_data
);

`include "assert_macros.svh"

    logic                         r_run;
    logic                         w_accept;
    logic [hkd_pkg::HUE_W-1:0]    r_hue_low;
    logic [hkd_pkg::HUE_W-1:0]    r_hue_high;
    logic [hkd_pkg::HUE_W-1:0]    n_hue_low;
    logic [hkd_pkg::HUE_W-1:0]    n_hue_high;

    logic                         w_valid [0:hkd_pkg::CELL_COUNT];
    hkd_pkg::t_div                w_div   [0:hkd_pkg::CELL_COUNT];

    hkd_pkg::t_div                w_last;
    logic [hkd_pkg::QUO_W:0]      w_ceil;
    logic [hkd_pkg::PROD_W-1:0]   w_prod;
    logic [hkd_pkg::HUE_W-1:0]    n_f1_hue;

    logic                         r_f1_valid;
    logic [hkd_pkg::HUE_W-1:0]    r_f1_hue;
    logic [hkd_pkg::CHAN_W-1:0]   r_f1_luma;
    logic [hkd_pkg::CHAN_W-1:0]   r_f1_red;
    logic [hkd_pkg::CHAN_W-1:0]   r_f1_green;
    logic [hkd_pkg::CHAN_W-1:0]   r_f1_blue;

    logic                         w_in_range;
    logic                         r_done;
    logic [hkd_pkg::CHAN_W-1:0]   r_red;
    logic [hkd_pkg::CHAN_W-1:0]   r_green;
    logic [hkd_pkg::CHAN_W-1:0]   r_blue;
    logic [hkd_pkg::HUE_W-1:0]    r_hue;

    assign busy        = ~r_run;
    assign w_accept    = start & ~busy;
    assign o_cfg_ready = 1'b1;

    // range registers
    always_comb begin
        n_hue_low  = r_hue_low;
        n_hue_high = r_hue_high;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hkd_pkg::CFG_HUE_LOW:  n_hue_low  = i_cfg_data;
                hkd_pkg::CFG_HUE_HIGH: n_hue_high = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_hue_low  <= hkd_pkg::HUE_LOW_RESET;
            r_hue_high <= hkd_pkg::HUE_HIGH_RESET;
        end else begin
            r_run      <= 1'b1;
            r_hue_low  <= n_hue_low;
            r_hue_high <= n_hue_high;
        end
    end

    hkd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (w_valid[0]),
        .o_div   (w_div[0])
    );

    for (genvar gi = 0; gi < hkd_pkg::CELL_COUNT; gi++) begin : g_cell
        hkd_cell #(
            .BIT_POS (hkd_pkg::CELL_COUNT - 1 - gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[gi]),
            .i_div   (w_div[gi]),
            .o_valid (w_valid[gi+1]),
            .o_div   (w_div[gi+1])
        );
    end

    // hue from base and quotient, luma by reciprocal
    assign w_last = w_div[hkd_pkg::CELL_COUNT];
    assign w_ceil = {1'b0, w_last.quo} + (hkd_pkg::QUO_W+1)'(w_last.rem != '0);
    assign w_prod = hkd_pkg::PROD_W'(w_last.pix.sum) * hkd_pkg::PROD_W'(hkd_pkg::LUMA_RECIP);

    always_comb begin
        if (w_last.pix.sub) begin
            n_f1_hue = w_last.pix.base - hkd_pkg::HUE_W'(w_ceil);
        end else begin
            n_f1_hue = w_last.pix.base + hkd_pkg::HUE_W'(w_last.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_f1_valid <= w_valid[hkd_pkg::CELL_COUNT];
            r_done     <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_hue   <= n_f1_hue;
        r_f1_luma  <= w_prod[hkd_pkg::LUMA_SHIFT +: hkd_pkg::CHAN_W];
        r_f1_red   <= w_last.pix.red;
        r_f1_green <= w_last.pix.green;
        r_f1_blue  <= w_last.pix.blue;
    end

    assign w_in_range = (r_f1_hue >= r_hue_low) && (r_f1_hue <= r_hue_high);

    always_ff @(posedge i_clk) begin
        r_hue   <= r_f1_hue;
        r_red   <= w_in_range ? r_f1_luma : r_f1_red;
        r_green <= w_in_range ? r_f1_luma : r_f1_green;
        r_blue  <= w_in_range ? r_f1_luma : r_f1_blue;
    end

    assign o_done      = r_done;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_hue_deg   = r_hue;

    `HKD_ASSERT_ALWAYS(a_done_latency, i_clk, i_rst_n, o_done == $past(w_accept, hkd_pkg::LATENCY), "result strobe out of step with requests")
    `HKD_ASSERT_IMP(a_hue_bound, i_clk, i_rst_n, o_done, o_hue_deg <= hkd_pkg::HUE_MAX, "hue beyond 359")
    `HKD_ASSERT_IMP(a_grey_hue, i_clk, i_rst_n, $past(w_accept && i_red_in == i_green_in && i_green_in == i_blue_in, hkd_pkg::LATENCY), o_hue_deg == '0, "grey pixel with nonzero hue")

endmodule

FILE: design/hkd_front.sv
// front stage: sector decode, divider operands and luma weighted sum
// depends on hkd_pkg
module hkd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hkd_pkg::CHAN_W-1:0] i_red,
    input  logic [hkd_pkg::CHAN_W-1:0] i_green,
    input  logic [hkd_pkg::CHAN_W-1:0] i_blue,
    output logic                       o_valid,
    output hkd_pkg::t_div              o_div
);

    logic [hkd_pkg::DEN_W-1:0] w_num;
    logic [hkd_pkg::DEN_W-1:0] w_den;
    logic [hkd_pkg::HUE_W-1:0] w_base;
    logic                      w_sub;
    logic [hkd_pkg::REM_W-1:0] w_num_x;
    logic                      r_valid;
    hkd_pkg::t_div             r_div;
    hkd_pkg::t_div             n_div;

    always_comb begin
        w_num  = '0;
        w_den  = 8'd1;
        w_base = hkd_pkg::HUE_BASE_RED;
        w_sub  = 1'b0;
        if (i_red >= i_green && i_green >= i_blue) begin
            // achromatic pixel keeps a zero quotient
            if (i_red != i_blue) begin
                w_num = i_green - i_blue;
                w_den = i_red - i_blue;
            end
        end else if (i_green > i_red && i_red >= i_blue) begin
            w_base = hkd_pkg::HUE_BASE_GREEN;
            w_sub  = 1'b1;
            w_num  = i_red - i_blue;
            w_den  = i_green - i_blue;
        end else if (i_green >= i_blue && i_blue > i_red) begin
            w_base = hkd_pkg::HUE_BASE_GREEN;
            w_num  = i_blue - i_red;
            w_den  = i_green - i_red;
        end else if (i_blue > i_green && i_green > i_red) begin
            w_base = hkd_pkg::HUE_BASE_BLUE;
            w_sub  = 1'b1;
            w_num  = i_green - i_red;
            w_den  = i_blue - i_red;
        end else if (i_blue > i_red && i_red >= i_green) begin
            w_base = hkd_pkg::HUE_BASE_BLUE;
            w_num  = i_red - i_green;
            w_den  = i_blue - i_green;
        end else if (i_red >= i_blue && i_blue > i_green) begin
            w_base = hkd_pkg::HUE_BASE_WRAP;
            w_sub  = 1'b1;
            w_num  = i_blue - i_green;
            w_den  = i_red - i_green;
        end
    end

    // sixty times the numerator
    assign w_num_x = (hkd_pkg::REM_W'(w_num) << 6) - (hkd_pkg::REM_W'(w_num) << 2);

    always_comb begin
        n_div           = '0;
        n_div.rem       = w_num_x;
        n_div.den       = w_den;
        n_div.quo       = '0;
        n_div.pix.red   = i_red;
        n_div.pix.green = i_green;
        n_div.pix.blue  = i_blue;
        n_div.pix.base  = w_base;
        n_div.pix.sub   = w_sub;
        n_div.pix.sum   = hkd_pkg::LUMA_WR * hkd_pkg::SUM_W'(i_red)
                        + hkd_pkg::LUMA_WG * hkd_pkg::SUM_W'(i_green)
                        + hkd_pkg::LUMA_WB * hkd_pkg::SUM_W'(i_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

FILE: design/hkd_cell.sv
// one restoring division cell: settles one quotient bit per clock
// depends on hkd_pkg
module hkd_cell #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hkd_pkg::t_div i_div,
    output logic          o_valid,
    output hkd_pkg::t_div o_div
);

    logic [hkd_pkg::REM_W-1:0] w_trial;
    logic                      w_fits;
    logic                      r_valid;
    hkd_pkg::t_div             r_div;
    hkd_pkg::t_div             n_div;

    assign w_trial = hkd_pkg::REM_W'(i_div.den) << BIT_POS;
    assign w_fits  = i_div.rem >= w_trial;

    always_comb begin
        n_div = i_div;
        if (w_fits) begin
            n_div.rem          = i_div.rem - w_trial;
            n_div.quo[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

FILE: dv/tb_hue_keyed_desaturation_top.sv
// testbench for the hue keyed desaturation block: directed and random pixels
// over several hue ranges, each result checked against an in-bench predictor
// depends on hkd_pkg and hue_keyed_desaturation_top
`timescale 1ns / 1ps

module tb_hue_keyed_desaturation_top;

    localparam int unsigned CHAN_W      = hkd_pkg::CHAN_W;
    localparam int unsigned HUE_W       = hkd_pkg::HUE_W;
    localparam int unsigned DEG_SECTOR  = 60;
    localparam int unsigned DEG_FULL    = 360;
    localparam int unsigned WEIGHT_R    = 299;
    localparam int unsigned WEIGHT_G    = 587;
    localparam int unsigned WEIGHT_B    = 114;
    localparam int unsigned WEIGHT_DIV  = 1000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned NUM_PHASES  = 12;
    localparam int unsigned PHASE_ITEMS = 50;

    typedef hkd_pkg::t_cfg_index t_cfg_index;

    localparam t_cfg_index  CFG_SPARE_A = 2'd2;
    localparam t_cfg_index  CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [HUE_W-1:0]  hue;
    } t_pixel_out;

    class hue_desat_scoreboard;
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
        t_pixel_out       pending[$];
        int unsigned      mismatches;

        function new();
            hue_low    = hkd_pkg::HUE_LOW_RESET;
            hue_high   = hkd_pkg::HUE_HIGH_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [HUE_W-1:0] data);
            case (idx)
                hkd_pkg::CFG_HUE_LOW:  hue_low = data;
                hkd_pkg::CFG_HUE_HIGH: hue_high = data;
                default: ;
            endcase
        endfunction

        function logic [HUE_W-1:0] hue_of(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                          logic [CHAN_W-1:0] blue);
            int unsigned r;
            int unsigned g;
            int unsigned b;
            int unsigned h;
            r = red;
            g = green;
            b = blue;
            if (r >= g && g >= b) begin
                h = (r == b) ? 0 : (DEG_SECTOR * (g - b)) / (r - b);
            end else if (g > r && r >= b) begin
                h = (2 * DEG_SECTOR * (g - b) - DEG_SECTOR * (r - b)) / (g - b);
            end else if (g >= b && b > r) begin
                h = 2 * DEG_SECTOR + (DEG_SECTOR * (b - r)) / (g - r);
            end else if (b > g && g > r) begin
                h = (4 * DEG_SECTOR * (b - r) - DEG_SECTOR * (g - r)) / (b - r);
            end else if (b > r && r >= g) begin
                h = 4 * DEG_SECTOR + (DEG_SECTOR * (r - g)) / (b - g);
            end else if (r >= b && b > g) begin
                h = (6 * DEG_SECTOR * (r - g) - DEG_SECTOR * (b - g)) / (r - g);
            end else begin
                h = 0;
            end
            return HUE_W'(h % DEG_FULL);
        endfunction

        function void note_request(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                   logic [CHAN_W-1:0] b);
            t_pixel_out  want;
            int unsigned luma;
            want.hue = hue_of(r, g, b);
            luma = (WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b) / WEIGHT_DIV;
            if (want.hue >= hue_low && want.hue <= hue_high) begin
                want.red   = CHAN_W'(luma);
                want.green = CHAN_W'(luma);
                want.blue  = CHAN_W'(luma);
            end else begin
                want.red   = r;
                want.green = g;
                want.blue  = b;
            end
            pending.push_back(want);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                   logic [CHAN_W-1:0] b, logic [HUE_W-1:0] h);
            t_pixel_out want;
            if (pending.size() == 0) begin
                flag($sformatf("unexpected result r=%0d g=%0d b=%0d hue=%0d", r, g, b, h));
                return;
            end
            want = pending.pop_front();
            if (r !== want.red || g !== want.green || b !== want.blue || h !== want.hue)
                flag({$sformatf("mismatch: expected r=%0d g=%0d b=%0d hue=%0d, ",
                                want.red, want.green, want.blue, want.hue),
                      $sformatf("got r=%0d g=%0d b=%0d hue=%0d", r, g, b, h)});
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CHAN_W-1:0] i_red_in = '0;
    logic [CHAN_W-1:0] i_green_in = '0;
    logic [CHAN_W-1:0] i_blue_in = '0;
    logic              o_done;
    logic [CHAN_W-1:0] o_red_out;
    logic [CHAN_W-1:0] o_green_out;
    logic [CHAN_W-1:0] o_blue_out;
    logic [HUE_W-1:0]  o_hue_deg;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    t_cfg_index        i_cfg_index = hkd_pkg::CFG_HUE_LOW;
    logic [HUE_W-1:0]  i_cfg_data = '0;

    hue_desat_scoreboard pixel_sb = new();

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    hue_keyed_desaturation_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_done      (o_done),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_hue_deg   (o_hue_deg),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            pixel_sb.check_result(o_red_out, o_green_out, o_blue_out, o_hue_deg);
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        @(negedge i_clk);
        start      <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (busy);
        pixel_sb.note_request(r, g, b);
    endtask

    task automatic hold_off(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results();
        hold_off(1);
        while (pixel_sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [HUE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pixel_sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAN_W-1:0] edge_channel();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic random_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
                                output logic [CHAN_W-1:0] b);
        int unsigned base;
        base = $urandom_range(0, 253);
        case ($urandom_range(0, 9))
            6: begin
                r = CHAN_W'(base);
                g = r;
                b = r;
            end
            7: begin
                r = CHAN_W'(base + $urandom_range(0, 2));
                g = CHAN_W'(base + $urandom_range(0, 2));
                b = CHAN_W'(base + $urandom_range(0, 2));
            end
            8: begin
                r = edge_channel();
                g = edge_channel();
                b = edge_channel();
            end
            9: begin
                // cyan to blue family, around the default range
                r = CHAN_W'($urandom_range(0, 40));
                g = CHAN_W'($urandom);
                b = CHAN_W'($urandom_range(64, 255));
            end
            default: begin
                r = CHAN_W'($urandom);
                g = CHAN_W'($urandom);
                b = CHAN_W'($urandom);
            end
        endcase
    endtask

    initial begin
        logic [HUE_W-1:0]  low_tab  [NUM_PHASES];
        logic [HUE_W-1:0]  high_tab [NUM_PHASES];
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;

        low_tab  = '{9'd0,   9'd0, 9'd359, 9'd360, 9'd300, 9'd511, 9'd0,   9'd359,
                     9'd0,   9'd0, 9'd120, 9'd180};
        high_tab = '{9'd511, 9'd0, 9'd359, 9'd511, 9'd100, 9'd0,   9'd359, 9'd511,
                     9'd0,   9'd0, 9'd240, 9'd230};
        low_tab[8]  = HUE_W'($urandom_range(0, 359));
        high_tab[8] = HUE_W'($urandom_range(low_tab[8], 359));
        low_tab[9]  = HUE_W'($urandom_range(0, 511));
        high_tab[9] = HUE_W'($urandom_range(0, 511));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // primaries, greys and the edges of the default range
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd0,   8'd1,   8'd2);
        send_pixel(8'd0,   8'd60,  8'd59);
        send_pixel(8'd0,   8'd1,   8'd6);
        send_pixel(8'd0,   8'd3,   8'd20);
        send_pixel(8'd0,   8'd128, 8'd255);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd255, 8'd1,   8'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_reg(hkd_pkg::CFG_HUE_LOW, low_tab[p]);
            write_reg(hkd_pkg::CFG_HUE_HIGH, high_tab[p]);
            if (p == 3 || p == 9) begin
                // writes to unmapped indices must leave the range alone
                write_reg(CFG_SPARE_A, HUE_W'($urandom));
                write_reg(CFG_SPARE_B, HUE_W'($urandom));
            end
            send_pixel(8'd128, 8'd128, 8'd128);
            send_pixel(8'd255, 8'd0,   8'd1);
            send_pixel(8'd0,   8'd255, 8'd255);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p < NUM_PHASES - 1 && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 5));
                random_pixel(r, g, b);
                send_pixel(r, g, b);
            end
        end

        drain_results();
        repeat (hkd_pkg::LATENCY + 4) @(posedge i_clk);
        if (pixel_sb.mismatches == 0 && pixel_sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
